// File: hdl/mwa_pkg.sv
`timescale 1ns / 1ps

package mwa_pkg;

    // Field widths of the request and result channels.
    localparam int CHANNEL_W = 2;
    localparam int SAMPLE_W  = 12;
    localparam int AVG_W     = 16;
    localparam int MV_W      = 12;

    // Fraction bits of the raw average.
    localparam int FRAC_BITS = 4;

    // Converter full scale: code 4095 stands for 3300 mV.
    localparam int FULL_SCALE_MV   = 3300;
    localparam int FULL_SCALE_CODE = 4095;

    // The millivolt ratio reduced by its common factor: 3300/4095 = 220/273.
    localparam int MV_GCD = 15;
    localparam int MV_NUM = FULL_SCALE_MV / MV_GCD;
    localparam int MV_DEN = FULL_SCALE_CODE / MV_GCD;
    localparam int MV_NUM_W = $clog2(MV_NUM + 1);

    // Default sizes.
    localparam int DEF_NUM_CHANNELS = 4;
    localparam int DEF_SAMPLES      = 16;

    // Result buffer depth; it also bounds the requests in flight.
    localparam int OUT_DEPTH = 8;

    // Control that travels with a request through the pipeline.
    typedef struct packed {
        logic                 valid;
        logic                 ok;
        logic [CHANNEL_W-1:0] channel;
    } ctl_t;

    // One buffered result.
    typedef struct packed {
        logic [CHANNEL_W-1:0] channel;
        logic [AVG_W-1:0]     avg;
        logic [MV_W-1:0]      mv;
    } res_t;

endpackage

// File: hdl/mwa_if.sv
`timescale 1ns / 1ps

// Sample request channel.
interface mwa_in_if;
    import mwa_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CHANNEL_W-1:0] channel;
    logic [SAMPLE_W-1:0]  sample;

    modport source (output valid, output channel, output sample, input ready);
    modport sink (input valid, input channel, input sample, output ready);
endinterface

// Average result channel.
interface mwa_out_if;
    import mwa_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CHANNEL_W-1:0] out_channel;
    logic [AVG_W-1:0]     avg_raw;
    logic [MV_W-1:0]      avg_millivolts;

    modport source (output valid, output out_channel, output avg_raw,
                    output avg_millivolts, input ready);
    modport sink (input valid, input out_channel, input avg_raw,
                  input avg_millivolts, output ready);
endinterface

// File: hdl/mwa_update.sv
`timescale 1ns / 1ps

module mwa_update #(
    parameter int NUM_CHANNELS = mwa_pkg::DEF_NUM_CHANNELS,
    parameter int SAMPLES      = mwa_pkg::DEF_SAMPLES,
    parameter int SUM_W        = $clog2(SAMPLES * mwa_pkg::FULL_SCALE_CODE + 1)
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_fire,
    input  logic [mwa_pkg::CHANNEL_W-1:0]  in_channel,
    input  logic [mwa_pkg::SAMPLE_W-1:0]   in_sample,
    output logic                           busy,
    output mwa_pkg::ctl_t                  upd_ctl,
    output logic [SUM_W-1:0]               upd_sum
);
    import mwa_pkg::*;

    localparam int RING_DEPTH = NUM_CHANNELS * SAMPLES;
    localparam int RING_AW    = $clog2(RING_DEPTH);
    localparam int POS_W      = $clog2(SAMPLES);
    localparam int SUM_AW     = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    // Sample ring and running sums, both synchronous memories.
    logic [SAMPLE_W-1:0] ring_mem [RING_DEPTH];
    logic [SUM_W-1:0]    sum_mem [NUM_CHANNELS];

    logic [POS_W-1:0]    wpos_reg;
    logic                clr_active_reg;
    logic [RING_AW-1:0]  clr_idx_reg;

    // Request stage: lookup address and forwarding decisions.
    logic                ok0;
    logic                last0;
    logic [RING_AW-1:0]  addr0;
    logic [SUM_AW-1:0]   sidx0;

    // Update stage registers.
    logic                s1_valid_reg;
    logic                s1_ok_reg;
    logic [CHANNEL_W-1:0] s1_ch_reg;
    logic [SAMPLE_W-1:0] s1_sample_reg;
    logic [RING_AW-1:0]  s1_addr_reg;
    logic [SUM_AW-1:0]   s1_sidx_reg;
    logic [SAMPLE_W-1:0] ring_q_reg;
    logic [SUM_W-1:0]    sum_q_reg;
    logic                fwd_ring_hit_reg;
    logic [SAMPLE_W-1:0] fwd_ring_val_reg;
    logic                fwd_sum_hit_reg;
    logic [SUM_W-1:0]    fwd_sum_val_reg;

    logic [SAMPLE_W-1:0] old_sample;
    logic [SUM_W-1:0]    old_sum;
    logic [SUM_W-1:0]    sum_new;

    // Memory write ports, shared by the clearing sweep and the update stage.
    logic                ring_we;
    logic [RING_AW-1:0]  ring_waddr;
    logic [SAMPLE_W-1:0] ring_wdata;
    logic                sum_we;
    logic [SUM_AW-1:0]   sum_waddr;
    logic [SUM_W-1:0]    sum_wdata;

    // Output stage registers.
    ctl_t                upd_ctl_reg;
    logic [SUM_W-1:0]    upd_sum_reg;

    assign ok0   = 32'(in_channel) < NUM_CHANNELS;
    assign last0 = 32'(in_channel) == NUM_CHANNELS - 1;
    assign addr0 = RING_AW'(32'(in_channel) * SAMPLES + 32'(wpos_reg));
    assign sidx0 = SUM_AW'(in_channel);

    // Read-modify-write: take the forwarded value when the previous request
    // wrote the same entry in the cycle this one was read.
    assign old_sample = fwd_ring_hit_reg ? fwd_ring_val_reg : ring_q_reg;
    assign old_sum    = fwd_sum_hit_reg ? fwd_sum_val_reg : sum_q_reg;
    assign sum_new    = old_sum - SUM_W'(old_sample) + SUM_W'(s1_sample_reg);

    always_comb
    begin
        if (clr_active_reg)
        begin
            ring_we    = 1'b1;
            ring_waddr = clr_idx_reg;
            ring_wdata = '0;
            sum_we     = 32'(clr_idx_reg) < NUM_CHANNELS;
            sum_waddr  = SUM_AW'(clr_idx_reg);
            sum_wdata  = '0;
        end
        else
        begin
            ring_we    = s1_valid_reg && s1_ok_reg;
            ring_waddr = s1_addr_reg;
            ring_wdata = s1_sample_reg;
            sum_we     = s1_valid_reg && s1_ok_reg;
            sum_waddr  = s1_sidx_reg;
            sum_wdata  = sum_new;
        end
    end

    // Ring memory.
    always_ff @(posedge clk)
    begin
        if (ring_we)
        begin
            ring_mem[ring_waddr] <= ring_wdata;
        end
        if (in_fire)
        begin
            ring_q_reg <= ring_mem[addr0];
        end
    end

    // Sum memory.
    always_ff @(posedge clk)
    begin
        if (sum_we)
        begin
            sum_mem[sum_waddr] <= sum_wdata;
        end
        if (in_fire)
        begin
            sum_q_reg <= sum_mem[sidx0];
        end
    end

    // Update stage payload and forwarding values.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_ok_reg        <= ok0;
            s1_ch_reg        <= in_channel;
            s1_sample_reg    <= in_sample;
            s1_addr_reg      <= addr0;
            s1_sidx_reg      <= sidx0;
            fwd_ring_hit_reg <= s1_valid_reg && s1_ok_reg && (s1_addr_reg == addr0);
            fwd_ring_val_reg <= s1_sample_reg;
            fwd_sum_hit_reg  <= s1_valid_reg && s1_ok_reg && (s1_sidx_reg == sidx0);
            fwd_sum_val_reg  <= sum_new;
        end
        upd_sum_reg <= s1_ok_reg ? sum_new : '0;
    end

    // Control: clearing sweep, write position and stage valids.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_idx_reg    <= '0;
            wpos_reg       <= '0;
            s1_valid_reg   <= 1'b0;
            upd_ctl_reg    <= '0;
        end
        else
        begin
            if (clr_active_reg)
            begin
                if (clr_idx_reg == RING_AW'(RING_DEPTH - 1))
                begin
                    clr_active_reg <= 1'b0;
                end
                clr_idx_reg <= clr_idx_reg + 1'b1;
            end
            if (in_fire && ok0 && last0)
            begin
                wpos_reg <= (wpos_reg == POS_W'(SAMPLES - 1)) ? '0 : wpos_reg + 1'b1;
            end
            s1_valid_reg        <= in_fire;
            upd_ctl_reg.valid   <= s1_valid_reg;
            upd_ctl_reg.ok      <= s1_ok_reg;
            upd_ctl_reg.channel <= s1_ch_reg;
        end
    end

    assign busy    = clr_active_reg;
    assign upd_ctl = upd_ctl_reg;
    assign upd_sum = upd_sum_reg;

endmodule

// File: hdl/mwa_scale.sv
`timescale 1ns / 1ps

module mwa_scale #(
    parameter int SAMPLES = mwa_pkg::DEF_SAMPLES,
    parameter int SUM_W   = $clog2(SAMPLES * mwa_pkg::FULL_SCALE_CODE + 1)
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  mwa_pkg::ctl_t              in_ctl,
    input  logic [SUM_W-1:0]           in_sum,
    output mwa_pkg::ctl_t              out_ctl,
    output logic [mwa_pkg::AVG_W-1:0]  out_avg,
    output logic [mwa_pkg::MV_W-1:0]   out_mv
);
    import mwa_pkg::*;

    // Both divisions by constants are done as a multiply by a rounded-up
    // reciprocal with enough extra bits that the floor is exact for every
    // dividend below 2**N.
    localparam int AVG_N     = SUM_W + FRAC_BITS;
    localparam int AVG_L     = $clog2(SAMPLES);
    localparam int AVG_SHIFT = AVG_N + AVG_L;
    localparam int AVG_PW    = 2 * AVG_N + 1;
    localparam logic [63:0] AVG_MUL_FULL =
        ((64'd1 << AVG_SHIFT) + 64'(SAMPLES) - 64'd1) / 64'(SAMPLES);
    localparam logic [AVG_N:0] AVG_MUL = AVG_MUL_FULL[AVG_N:0];

    localparam int MV_N     = SUM_W + MV_NUM_W;
    localparam int MV_DIV   = MV_DEN * SAMPLES;
    localparam int MV_L     = $clog2(MV_DIV);
    localparam int MV_SHIFT = MV_N + MV_L;
    localparam int MV_PW    = 2 * MV_N + 1;
    localparam logic [63:0] MV_MUL_FULL =
        ((64'd1 << MV_SHIFT) + 64'(MV_DIV) - 64'd1) / 64'(MV_DIV);
    localparam logic [MV_N:0] MV_MUL = MV_MUL_FULL[MV_N:0];

    ctl_t              a_ctl_reg;
    logic [AVG_PW-1:0] avg_prod_reg;
    logic [MV_N-1:0]   mv_part_reg;
    ctl_t              b_ctl_reg;
    logic [AVG_W-1:0]  avg_reg;
    logic [MV_PW-1:0]  mv_prod_reg;

    // First stage: raw average product and millivolt numerator.
    // Second stage: raw average taken out, millivolt reciprocal product.
    always_ff @(posedge clk)
    begin
        avg_prod_reg <= (AVG_PW'(in_sum) << FRAC_BITS) * AVG_PW'(AVG_MUL);
        mv_part_reg  <= MV_N'(in_sum) * MV_N'(MV_NUM);
        avg_reg      <= AVG_W'(avg_prod_reg >> AVG_SHIFT);
        mv_prod_reg  <= MV_PW'(mv_part_reg) * MV_PW'(MV_MUL);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_ctl_reg <= '0;
            b_ctl_reg <= '0;
        end
        else
        begin
            a_ctl_reg <= in_ctl;
            b_ctl_reg <= a_ctl_reg;
        end
    end

    assign out_ctl = b_ctl_reg;
    assign out_avg = avg_reg;
    assign out_mv  = MV_W'(mv_prod_reg >> MV_SHIFT);

endmodule

// File: hdl/multichannel_window_averager.sv
`timescale 1ns / 1ps

// Multichannel boxcar averager for 12-bit converter samples.
// Requests arrive on the samples channel (channel, sample); each request
// yields exactly one result on the averages channel, in request order:
// the channel, its window mean with 4 fraction bits, and the mean in mV.
// Each channel averages its last SAMPLES samples; the shared ring position
// advances after a sample for the highest channel. A request for a channel
// at or above NUM_CHANNELS leaves the state alone and reports zeros.
// The block takes one request per cycle while ready is high: the ring and
// the sums are read in one cycle and written back the next, with forwarding
// between back-to-back requests.
// After reset the block sweeps both memories to zero, one ring entry per
// cycle, until all NUM_CHANNELS * SAMPLES entries are clear; ready stays
// low meanwhile, so early averages count the missing samples as zero.
// Results wait in an 8-entry buffer. When the receiver stalls, requests are
// still taken until 8 are outstanding; ready then drops and rises again as
// results are taken.
module multichannel_window_averager #(
    parameter int NUM_CHANNELS = mwa_pkg::DEF_NUM_CHANNELS,
    parameter int SAMPLES      = mwa_pkg::DEF_SAMPLES
) (
    input logic        clk,
    input logic        rst_n,
    mwa_in_if.sink     samples,
    mwa_out_if.source  averages
);
    import mwa_pkg::*;

    localparam int SUM_W  = $clog2(SAMPLES * FULL_SCALE_CODE + 1);
    localparam int OUT_AW = $clog2(OUT_DEPTH);

    logic             busy;
    logic             in_fire;
    logic             out_fire;
    ctl_t             upd_ctl;
    logic [SUM_W-1:0] upd_sum;
    ctl_t             res_ctl;
    logic [AVG_W-1:0] res_avg;
    logic [MV_W-1:0]  res_mv;
    logic             push;

    res_t             fifo_mem [OUT_DEPTH];
    logic [OUT_AW-1:0] wr_ptr_reg;
    logic [OUT_AW-1:0] rd_ptr_reg;
    logic [OUT_AW:0]   fifo_cnt_reg;
    logic [OUT_AW:0]   fifo_cnt_next;
    logic [OUT_AW:0]   occ_reg;
    logic [OUT_AW:0]   occ_next;

    // Accept while fewer requests than the buffer depth are outstanding, and not during the clearing sweep.
    assign samples.ready = !busy && (occ_reg < (OUT_AW + 1)'(OUT_DEPTH));
    assign in_fire       = samples.valid && samples.ready;
    assign out_fire      = averages.valid && averages.ready;
    assign push          = res_ctl.valid;

    mwa_update #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .SAMPLES      (SAMPLES),
        .SUM_W        (SUM_W)
    ) u_update (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_fire    (in_fire),
        .in_channel (samples.channel),
        .in_sample  (samples.sample),
        .busy       (busy),
        .upd_ctl    (upd_ctl),
        .upd_sum    (upd_sum)
    );

    mwa_scale #(
        .SAMPLES (SAMPLES),
        .SUM_W   (SUM_W)
    ) u_scale (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ctl  (upd_ctl),
        .in_sum  (upd_sum),
        .out_ctl (res_ctl),
        .out_avg (res_avg),
        .out_mv  (res_mv)
    );

    // Result buffer storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_mem[wr_ptr_reg] <= '{channel: res_ctl.channel, avg: res_avg, mv: res_mv};
        end
    end

    // Outstanding request count and buffer fill.
    assign occ_next      = occ_reg + (OUT_AW + 1)'(in_fire) - (OUT_AW + 1)'(out_fire);
    assign fifo_cnt_next = fifo_cnt_reg + (OUT_AW + 1)'(push) - (OUT_AW + 1)'(out_fire);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            fifo_cnt_reg <= '0;
            occ_reg      <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (out_fire)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            fifo_cnt_reg <= fifo_cnt_next;
            occ_reg      <= occ_next;
        end
    end

    assign averages.valid          = fifo_cnt_reg != '0;
    assign averages.out_channel    = fifo_mem[rd_ptr_reg].channel;
    assign averages.avg_raw        = fifo_mem[rd_ptr_reg].avg;
    assign averages.avg_millivolts = fifo_mem[rd_ptr_reg].mv;

`ifndef NO_ASSERTIONS
    // Outstanding requests never exceed the buffer that must hold them.
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= (OUT_AW + 1)'(OUT_DEPTH))
        else $error("outstanding request count exceeds result buffer depth");

    // Buffered results are a subset of outstanding requests.
    a_fifo_le_occ: assert property (@(posedge clk) disable iff (!rst_n)
        fifo_cnt_reg <= occ_reg)
        else $error("result buffer holds more than the outstanding requests");

    // A result leaving the pipeline always has an accepted request behind it.
    a_push_credit: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (occ_reg > fifo_cnt_reg))
        else $error("result produced without an outstanding request");
`endif

endmodule

// File: tb/sv/multichannel_window_averager_test.sv
`timescale 1ns / 1ps

module multichannel_window_averager_test;
    import mwa_pkg::*;

    localparam int NUM_CH       = DEF_NUM_CHANNELS;
    localparam int WINDOW       = DEF_SAMPLES;
    localparam int LIMIT_CYCLES = 200000;
    localparam int DRAIN_CYCLES = 20;
    localparam int RANDOM_ITEMS = 1100;

    // The long stretch without any idling, counted in requests on each side.
    localparam int QUIET_FROM = 400;
    localparam int QUIET_TO   = 650;

    // Sample selection modes for the random rounds.
    typedef enum int {
        PICK_RANDOM,
        PICK_FULL,
        PICK_ZERO,
        PICK_CORNER
    } pick_mode_t;

    typedef struct packed {
        logic [CHANNEL_W-1:0] channel;
        logic [SAMPLE_W-1:0]  sample;
    } sample_req_t;

    logic clk;
    logic rst_n = 1'b0;

    mwa_in_if  samples_if ();
    mwa_out_if averages_if ();

    multichannel_window_averager #(
        .NUM_CHANNELS(NUM_CH),
        .SAMPLES     (WINDOW)
    ) uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (samples_if),
        .averages(averages_if)
    );

    // Requests waiting to be driven and averages waiting to be seen.
    sample_req_t pending_requests[$];
    res_t        expected_averages[$];
    sample_req_t next_request;
    res_t        want;

    // Shadow copy of the per-channel rings, running sums and write position.
    logic [SAMPLE_W-1:0] ring_copy [NUM_CH*WINDOW] = '{default: '0};
    logic [AVG_W-1:0]    sum_copy [NUM_CH] = '{default: '0};
    int unsigned         ring_pos;

    int unsigned requests_total;
    int unsigned requests_sent;
    int unsigned averages_seen;
    int unsigned error_count;
    int unsigned cycle_count;

    // Updates the shadow state with one sample and returns the average it yields.
    function automatic res_t window_average(input logic [CHANNEL_W-1:0] ch,
                                            input logic [SAMPLE_W-1:0] smp);
        res_t            r;
        int unsigned     slot;
        longint unsigned total;
        r.channel = ch;
        r.avg     = '0;
        r.mv      = '0;
        // A channel beyond the configured count leaves the state alone.
        if (int'(ch) < NUM_CH)
        begin
            slot = int'(ch) * WINDOW + ring_pos;
            sum_copy[ch]    = sum_copy[ch] - AVG_W'(ring_copy[slot]) + AVG_W'(smp);
            ring_copy[slot] = smp;
            if (int'(ch) == NUM_CH - 1)
            begin
                ring_pos = (ring_pos + 1) % WINDOW;
            end
            total = sum_copy[ch];
            r.avg = AVG_W'((total << FRAC_BITS) / WINDOW);
            r.mv  = MV_W'((total * FULL_SCALE_MV) / (longint'(FULL_SCALE_CODE) * WINDOW));
        end
        return r;
    endfunction

    function automatic void add_request(input int ch, input int smp);
        sample_req_t q;
        q.channel = CHANNEL_W'(ch);
        q.sample  = SAMPLE_W'(smp);
        pending_requests.push_back(q);
    endfunction

    function automatic int pick_sample(input pick_mode_t mode);
        int corners[4];
        corners = '{0, 12'hFFF, 12'h800, 12'h7FF};
        case (mode)
            PICK_FULL:   return 12'hFFF;
            PICK_ZERO:   return 0;
            PICK_CORNER: return ($urandom_range(3) == 0) ? $urandom_range(12'hFFF)
                                                         : corners[$urandom_range(3)];
            default:     return $urandom_range(12'hFFF);
        endcase
    endfunction

    // Random idling, except for one long stretch where the side never pauses.
    function automatic bit take_break(input int unsigned progress);
        if (progress >= QUIET_FROM && progress < QUIET_TO)
        begin
            return 1'b0;
        end
        return $urandom_range(99) < 33;
    endfunction

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    // Request driver: records the expected average when a request is taken.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            samples_if.valid   <= 1'b0;
            samples_if.channel <= '0;
            samples_if.sample  <= '0;
        end
        else
        begin
            if (samples_if.valid && samples_if.ready)
            begin
                expected_averages.push_back(window_average(samples_if.channel,
                                                           samples_if.sample));
                requests_sent++;
            end
            if (!samples_if.valid || samples_if.ready)
            begin
                if (pending_requests.size() > 0 && !take_break(requests_sent))
                begin
                    next_request = pending_requests.pop_front();
                    samples_if.valid   <= 1'b1;
                    samples_if.channel <= next_request.channel;
                    samples_if.sample  <= next_request.sample;
                end
                else
                begin
                    samples_if.valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: compares each taken average with the oldest expectation.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            averages_if.ready <= 1'b0;
        end
        else
        begin
            if (averages_if.valid && averages_if.ready)
            begin
                averages_seen++;
                if (expected_averages.size() == 0)
                begin
                    error_count++;
                    $display("%0t: unexpected average ch %0d avg %0d mv %0d", $time,
                             averages_if.out_channel, averages_if.avg_raw,
                             averages_if.avg_millivolts);
                end
                else
                begin
                    want = expected_averages.pop_front();
                    if (averages_if.out_channel !== want.channel ||
                        averages_if.avg_raw !== want.avg ||
                        averages_if.avg_millivolts !== want.mv)
                    begin
                        error_count++;
                        $display("%0t: expected ch %0d avg %0d mv %0d, got ch %0d avg %0d mv %0d",
                                 $time, want.channel, want.avg, want.mv,
                                 averages_if.out_channel, averages_if.avg_raw,
                                 averages_if.avg_millivolts);
                    end
                end
            end
            averages_if.ready <= !take_break(averages_seen);
        end
    end

    // Run limit.
    initial
    begin
        wait (cycle_count >= LIMIT_CYCLES);
        $display("DONE: errors detected");
        $finish;
    end

    // Stimulus, reset and end of run.
    initial
    begin
        int         rounds;
        int         seg_kind;
        int         skip_ch;
        pick_mode_t mode;

        // Early averages over a zero-filled ring, field extremes, and a channel
        // written twice at one position before the highest channel moves it on.
        add_request(0, 12'hFFF);
        add_request(1, 0);
        add_request(2, 12'hFFF);
        add_request(3, 12'h800);
        add_request(0, 12'hFFF);
        add_request(0, 12'h001);
        add_request(1, 12'hAAA);
        add_request(2, 12'h555);
        add_request(3, 12'hFFF);
        add_request(3, 0);
        add_request(0, 12'hFFF);
        add_request(1, 12'hFFF);
        add_request(2, 12'hFFF);
        add_request(3, 12'hFFF);
        add_request(2, 12'h7FF);
        add_request(1, 12'h800);
        add_request(0, 0);

        // Mostly complete rounds over all channels, some long enough to fill
        // the window at full scale or at zero; the rest broken rounds and noise.
        while (pending_requests.size() < RANDOM_ITEMS + 17)
        begin
            seg_kind = $urandom_range(9);
            if (seg_kind < 7)
            begin
                rounds = $urandom_range(4, 24);
                mode   = pick_mode_t'($urandom_range(3));
                for (int r = 0; r < rounds; r++)
                begin
                    skip_ch = ($urandom_range(15) == 0) ? $urandom_range(NUM_CH - 1) : -1;
                    for (int ch = 0; ch < NUM_CH; ch++)
                    begin
                        if (ch != skip_ch)
                        begin
                            add_request(ch, pick_sample(mode));
                        end
                    end
                end
            end
            else
            begin
                repeat ($urandom_range(2, 10))
                begin
                    add_request($urandom_range(3), pick_sample(PICK_RANDOM));
                end
            end
        end
        requests_total = pending_requests.size();

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        while (requests_sent < requests_total || expected_averages.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0 && expected_averages.size() == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
